// File: src/abg_pkg.sv
package abg_pkg;

  localparam int unsigned ADDR_BITS_DEF = 64;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam logic [2:0] BUS_LOG2_RST    = 3'd3;
  localparam logic [2:0] STROBE_LOG2_RST = 3'd3;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BEAT  = 1'b1;

  localparam logic [1:0] KIND_FIXED = 2'd0;
  localparam logic [1:0] KIND_INCR  = 2'd1;
  localparam logic [1:0] KIND_WRAP  = 2'd2;
  localparam logic [1:0] KIND_RSVD  = 2'd3;

  localparam logic [2:0] ATOM_NONE    = 3'd0;
  localparam logic [2:0] ATOM_STORE   = 3'd1;
  localparam logic [2:0] ATOM_LOAD    = 3'd2;
  localparam logic [2:0] ATOM_SWAP    = 3'd3;
  localparam logic [2:0] ATOM_COMPARE = 3'd4;

  localparam logic [2:0] FAULT_OK   = 3'd0;
  localparam logic [2:0] FAULT_IDLE = 3'd1;
  localparam logic [2:0] FAULT_SIZE = 3'd2;
  localparam logic [2:0] FAULT_WRAP = 3'd3;
  localparam logic [2:0] FAULT_RSVD = 3'd4;

  // register index = paddr[2]
  localparam logic REG_BUS    = 1'b0;
  localparam logic REG_STROBE = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [63:0] req_addr;
    logic [7:0]  beats_minus_one;
    logic [2:0]  beat_size_log2;
    logic [1:0]  burst_kind;
    logic        is_write;
    logic [2:0]  atomic_kind;
    logic        locked;
  } req_t;

  typedef struct packed {
    logic [63:0] beat_addr;
    logic [63:0] xfer_start;
    logic [7:0]  byte_count;
    logic [6:0]  low_lane;
    logic [6:0]  high_lane;
    logic        last_beat;
    logic        do_read;
    logic        do_write;
    logic        send_read_resp;
    logic        exokay;
    logic [2:0]  fault;
  } beat_t;

  typedef struct packed {
    logic [2:0] bus_log2;
    logic [2:0] strobe_log2;
  } cfg_t;

  // classified command between front and back
  typedef struct packed {
    logic        start;
    logic [2:0]  fault;
    logic [63:0] addr;
    logic [63:0] wrap_low;
    logic [11:0] off;
    logic [11:0] span;
    logic [7:0]  beats_minus_one;
    logic [2:0]  size;
    logic [1:0]  kind;
    logic        wr;
    logic [2:0]  atom;
    logic        lock;
  } op_t;

endpackage

// File: src/axi_burst_beat_generator_top.sv
// AXI burst beat address generator.
// Request channel (req_valid/req_stall/req): cmd 0 latches a burst request
// (start address, length, size, burst type, write/atomic/lock flags) and
// returns one result carrying only a fault code; cmd 1 yields the next beat.
// Result channel (beat_valid/beat_stall/beat): one result per request, in
// order: beat address, transfer start, byte lanes, byte count, last flag,
// read/write/response controls, EXOKAY, fault.
// Throughput: one request per cycle while req_stall is low; the next beat
// address is formed by a single address add per cycle in the back stage.
// A request accepted into the queue is moved into the output register when
// the result channel is free, and is offered from there.
// A two-entry queue separates the decode front from the beat back end;
// req_stall rises only when that queue is full, so a stalled result holds
// in the output register while the queue still takes requests.
// Reset: no burst active, queue and output empty, bus and strobe width
// registers at 8 bytes. The user must write the registers through the APB port
// (bus_bytes_log2 at 0x0, strobe_bytes_log2 at 0x4) only while idle; the block does not enforce this.
module axi_burst_beat_generator_top #(
  parameter int unsigned ADDR_BITS = abg_pkg::ADDR_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  abg_pkg::req_t  req,
  output logic           beat_valid,
  input  logic           beat_stall,
  output abg_pkg::beat_t beat,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  abg_pkg::cfg_t cfg;
  abg_pkg::op_t  front_op;
  abg_pkg::op_t  q_op;
  logic          q_full;
  logic          q_empty;
  logic          q_push;
  logic          q_pop;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bus_log2    <= abg_pkg::BUS_LOG2_RST;
      cfg.strobe_log2 <= abg_pkg::STROBE_LOG2_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        abg_pkg::REG_BUS:    cfg.bus_log2    <= pwdata[2:0];
        abg_pkg::REG_STROBE: cfg.strobe_log2 <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      abg_pkg::REG_BUS:    prdata = 32'(cfg.bus_log2);
      abg_pkg::REG_STROBE: prdata = 32'(cfg.strobe_log2);
      default:             prdata = '0;
    endcase
  end

  assign req_stall = q_full;
  assign q_push    = req_valid && !q_full;

  abg_front #(
    .ADDR_BITS(ADDR_BITS)
  ) u_front (
    .req (req),
    .cfg (cfg),
    .op  (front_op)
  );

  abg_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (front_op),
    .full    (q_full),
    .pop     (q_pop),
    .pop_op  (q_op),
    .empty   (q_empty)
  );

  abg_back #(
    .ADDR_BITS(ADDR_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (!q_empty),
    .q_op       (q_op),
    .pop        (q_pop),
    .beat_valid (beat_valid),
    .beat_stall (beat_stall),
    .beat       (beat)
  );

endmodule

// File: src/abg_front.sv
module abg_front #(
  parameter int unsigned ADDR_BITS = abg_pkg::ADDR_BITS_DEF
) (
  input  abg_pkg::req_t req,
  input  abg_pkg::cfg_t cfg,
  output abg_pkg::op_t  op
);

  logic [ADDR_BITS-1:0] addr;
  logic [2:0]           len_log2;
  logic [3:0]           span_log2;
  logic [11:0]          wmask;

  assign addr      = req.req_addr[ADDR_BITS-1:0];
  assign span_log2 = 4'(req.beat_size_log2) + 4'(len_log2);
  assign wmask     = ~(12'hfff << span_log2);

  always_comb begin
    case (req.beats_minus_one)
      8'd1:    len_log2 = 3'd1;
      8'd3:    len_log2 = 3'd2;
      8'd7:    len_log2 = 3'd3;
      8'd15:   len_log2 = 3'd4;
      default: len_log2 = 3'd0;
    endcase
  end

  always_comb begin
    op                 = '0;
    op.start           = (req.cmd == abg_pkg::CMD_START);
    op.addr            = 64'(addr);
    op.beats_minus_one = req.beats_minus_one;
    op.size            = req.beat_size_log2;
    op.kind            = req.burst_kind;
    op.wr              = req.is_write;
    op.atom            = req.atomic_kind;
    op.lock            = req.locked;
    if (op.start) begin
      if (req.beat_size_log2 > cfg.bus_log2) begin
        op.fault = abg_pkg::FAULT_SIZE;
      end else if (req.burst_kind == abg_pkg::KIND_RSVD) begin
        op.fault = abg_pkg::FAULT_RSVD;
      end else if (req.burst_kind == abg_pkg::KIND_WRAP &&
                   !(req.beats_minus_one inside {8'd1, 8'd3, 8'd7, 8'd15})) begin
        op.fault = abg_pkg::FAULT_WRAP;
      end
    end
    if (req.burst_kind == abg_pkg::KIND_WRAP) begin
      op.wrap_low = 64'(addr & ~ADDR_BITS'(wmask));
      op.off      = addr[11:0] & wmask;
      op.span     = 12'd1 << span_log2;
    end
  end

endmodule

// File: src/abg_queue.sv
module abg_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  abg_pkg::op_t  push_op,
  output logic          full,
  input  logic          pop,
  output abg_pkg::op_t  pop_op,
  output logic          empty
);

  localparam int unsigned DEPTH = abg_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  abg_pkg::op_t     slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign pop_op = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");

endmodule

// File: src/abg_back.sv
module abg_back #(
  parameter int unsigned ADDR_BITS = abg_pkg::ADDR_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  abg_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  abg_pkg::op_t   q_op,
  output logic           pop,
  output logic           beat_valid,
  input  logic           beat_stall,
  output abg_pkg::beat_t beat
);

  logic                 active;
  logic [ADDR_BITS-1:0] cur;
  logic [ADDR_BITS-1:0] wrap_low;
  logic [11:0]          off;
  logic [11:0]          span;
  logic [7:0]           left;
  logic [2:0]           size;
  logic [1:0]           kind;
  logic                 wr;
  logic [2:0]           atom;
  logic                 lock;

  logic [6:0]           nb_mask;
  logic [6:0]           bus_mask;
  logic [6:0]           strobe_mask;
  logic [6:0]           lo;
  logic [6:0]           sub;
  logic [7:0]           nb;
  logic [7:0]           cnt;
  logic [7:0]           hi;
  logic                 aligned;
  logic                 last;
  logic                 rd;
  logic                 rresp;
  logic                 wrap_hit;
  logic [ADDR_BITS-1:0] xfer;
  logic [ADDR_BITS-1:0] lin_next;
  logic [12:0]          off_lin;
  abg_pkg::beat_t       res;

  assign pop = q_valid && (!beat_valid || !beat_stall);

  assign nb          = 8'd1 << size;
  assign nb_mask     = ~(7'h7f << size);
  assign bus_mask    = ~(7'h7f << cfg.bus_log2);
  assign strobe_mask = ~(7'h7f << cfg.strobe_log2);
  assign lo          = cur[6:0] & bus_mask;
  assign sub         = cur[6:0] & nb_mask;
  assign aligned     = (sub == '0);
  assign cnt         = nb - {1'b0, sub};
  assign hi          = {1'b0, lo} + cnt - 8'd1;
  assign xfer        = (cur & ~ADDR_BITS'(strobe_mask)) + ADDR_BITS'(lo);
  assign lin_next    = (cur & ~ADDR_BITS'(nb_mask)) + ADDR_BITS'(nb);
  assign off_lin     = {1'b0, off & ~{5'd0, nb_mask}} + {5'd0, nb};
  assign wrap_hit    = aligned && (kind == abg_pkg::KIND_WRAP) && (off_lin >= {1'b0, span});
  assign last        = (left == '0);
  assign rd          = !wr || (atom != abg_pkg::ATOM_NONE);
  assign rresp       = !wr || (atom != abg_pkg::ATOM_NONE && atom != abg_pkg::ATOM_STORE);

  always_comb begin
    res = '0;
    if (q_op.start) begin
      res.fault = q_op.fault;
    end else if (!active) begin
      res.fault = abg_pkg::FAULT_IDLE;
    end else begin
      res.beat_addr      = 64'(cur);
      res.xfer_start     = 64'(xfer);
      res.byte_count     = cnt;
      res.low_lane       = lo;
      res.high_lane      = hi[6:0];
      res.last_beat      = last;
      res.do_read        = rd;
      res.do_write       = wr;
      res.send_read_resp = rresp;
      res.exokay         = rresp && lock;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      beat_valid <= 1'b0;
    end else begin
      if (pop) begin
        beat_valid <= 1'b1;
        if (q_op.start) begin
          active <= (q_op.fault == abg_pkg::FAULT_OK);
        end else if (active && last) begin
          active <= 1'b0;
        end
      end else if (!beat_stall) begin
        beat_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      beat <= res;
      if (q_op.start) begin
        if (q_op.fault == abg_pkg::FAULT_OK) begin
          cur      <= q_op.addr[ADDR_BITS-1:0];
          wrap_low <= q_op.wrap_low[ADDR_BITS-1:0];
          off      <= q_op.off;
          span     <= q_op.span;
          left     <= q_op.beats_minus_one;
          size     <= q_op.size;
          kind     <= q_op.kind;
          wr       <= q_op.wr;
          atom     <= q_op.atom;
          lock     <= q_op.lock;
        end
      end else if (active) begin
        left <= left - 8'd1;
        if (kind != abg_pkg::KIND_FIXED) begin
          if (wrap_hit) begin
            cur <= wrap_low;
            off <= '0;
          end else begin
            cur <= lin_next;
            off <= off_lin[11:0];
          end
        end
      end
    end
  end

  a_start_arms: assert property (@(posedge clk) disable iff (rst)
    (pop && q_op.start && q_op.fault == abg_pkg::FAULT_OK) |=> active)
    else $error("good start did not arm burst");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (pop && !q_op.start && active && left == '0) |=> !active)
    else $error("burst still active after last beat");

  a_fault_empty: assert property (@(posedge clk) disable iff (rst)
    (beat_valid && beat.fault != abg_pkg::FAULT_OK) |->
      (beat.byte_count == '0 && !beat.last_beat))
    else $error("faulted result carries a beat");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    beat_valid |-> beat.byte_count <= 8'd128)
    else $error("byte count beyond bus maximum");

endmodule

// File: tb/axi_burst_beat_generator_top_test.sv
`timescale 1ns / 100ps

module axi_burst_beat_generator_top_test;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 220;
  localparam int LONG_HOLD    = 40;
  localparam int SETTLE       = 6;

  typedef struct {
    abg_pkg::req_t  stim;
    bit             typed;
    abg_pkg::beat_t want;
  } dir_row_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_stall;
  abg_pkg::req_t  req = '0;
  logic           beat_valid;
  logic           beat_stall = 1'b0;
  abg_pkg::beat_t beat;
  logic           psel = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite = 1'b0;
  logic [2:0]     paddr = '0;
  logic [31:0]    pwdata = '0;
  logic [31:0]    prdata;
  logic           pready;

  axi_burst_beat_generator_top dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .beat_valid(beat_valid), .beat_stall(beat_stall), .beat(beat),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // burst tracking state of the predictor
  logic [2:0]  bus_lg = abg_pkg::BUS_LOG2_RST;
  logic [2:0]  strobe_lg = abg_pkg::STROBE_LOG2_RST;
  logic        run_active = 1'b0;
  logic        run_aligned = 1'b0;
  logic [63:0] run_addr = '0;
  logic [63:0] run_first = '0;
  logic [63:0] run_wlo = '0;
  logic [63:0] run_whi = '0;
  logic [8:0]  run_idx = '0;
  logic [8:0]  run_total = '0;
  logic [2:0]  run_size = '0;
  logic [1:0]  run_kind = '0;
  logic        run_wr = 1'b0;
  logic [2:0]  run_atom = '0;
  logic        run_lock = 1'b0;

  abg_pkg::beat_t pending_beats[$];
  dir_row_t       dir_rows[$];
  abg_pkg::beat_t due_beat;
  int             mismatches = 0;
  int             cycle_cnt = 0;
  int             items_sent = 0;
  int             tx_idle = 0;
  int             rx_idle = 0;
  int             hold_trig = 0;
  int             hold_seen = 0;
  int             hold_left = 0;

  function automatic abg_pkg::beat_t step_burst(abg_pkg::req_t r);
    abg_pkg::beat_t b;
    logic [63:0]    nb, bus, strobe, lo, hi, nx, dt;
    logic [8:0]     len1;
    logic [2:0]     f;
    logic           is_last, rd, rresp;
    b = '0;
    if (r.cmd == abg_pkg::CMD_START) begin
      len1 = {1'b0, r.beats_minus_one} + 9'd1;
      nb = 64'd1 << r.beat_size_log2;
      f = abg_pkg::FAULT_OK;
      if (r.beat_size_log2 > bus_lg) f = abg_pkg::FAULT_SIZE;
      else if (r.burst_kind == abg_pkg::KIND_RSVD) f = abg_pkg::FAULT_RSVD;
      else if (r.burst_kind == abg_pkg::KIND_WRAP && len1 != 9'd2 && len1 != 9'd4 &&
               len1 != 9'd8 && len1 != 9'd16) f = abg_pkg::FAULT_WRAP;
      b.fault = f;
      if (f != abg_pkg::FAULT_OK) begin
        run_active = 1'b0;
        return b;
      end
      run_active = 1'b1;
      run_addr = r.req_addr;
      run_first = r.req_addr & ~(nb - 64'd1);
      run_aligned = (r.req_addr == run_first);
      if (r.burst_kind == abg_pkg::KIND_WRAP) begin
        dt = nb * 64'(len1);
        run_wlo = r.req_addr & ~(dt - 64'd1);
        run_whi = run_wlo + dt;
      end else begin
        run_wlo = '0;
        run_whi = '0;
      end
      run_idx = '0;
      run_total = len1;
      run_size = r.beat_size_log2;
      run_kind = r.burst_kind;
      run_wr = r.is_write;
      run_atom = r.atomic_kind;
      run_lock = r.locked;
      return b;
    end
    if (!run_active) begin
      b.fault = abg_pkg::FAULT_IDLE;
      return b;
    end
    nb = 64'd1 << run_size;
    bus = 64'd1 << bus_lg;
    strobe = 64'd1 << strobe_lg;
    lo = run_addr & (bus - 64'd1);
    if (run_aligned) hi = lo + nb - 64'd1;
    else hi = lo + (nb - (run_addr - run_first)) - 64'd1;
    is_last = (10'(run_idx) + 10'd1) >= 10'(run_total);
    rd = !run_wr || run_atom != abg_pkg::ATOM_NONE;
    rresp = !run_wr || (run_atom != abg_pkg::ATOM_NONE && run_atom != abg_pkg::ATOM_STORE);
    b.beat_addr = run_addr;
    b.xfer_start = (run_addr & ~(strobe - 64'd1)) + lo;
    b.byte_count = 8'(hi - lo + 64'd1);
    b.low_lane = lo[6:0];
    b.high_lane = hi[6:0];
    b.last_beat = is_last;
    b.do_read = rd;
    b.do_write = run_wr;
    b.send_read_resp = rresp;
    b.exokay = rresp && run_lock;
    b.fault = abg_pkg::FAULT_OK;
    if (run_kind != abg_pkg::KIND_FIXED) begin
      if (run_aligned) begin
        nx = run_addr + nb;
        if (run_kind == abg_pkg::KIND_WRAP && (nx - run_wlo) >= (run_whi - run_wlo))
          nx = run_wlo;
        run_addr = nx;
      end else begin
        run_addr = run_first + nb;
        run_aligned = 1'b1;
      end
    end
    run_idx = run_idx + 9'd1;
    if (is_last) run_active = 1'b0;
    return b;
  endfunction

  function automatic abg_pkg::req_t mk_req(logic cmd, logic [63:0] addr, logic [7:0] bml,
                                           logic [2:0] size, logic [1:0] kind, logic wr,
                                           logic [2:0] atom, logic lock);
    abg_pkg::req_t r;
    r.cmd = cmd;
    r.req_addr = addr;
    r.beats_minus_one = bml;
    r.beat_size_log2 = size;
    r.burst_kind = kind;
    r.is_write = wr;
    r.atomic_kind = atom;
    r.locked = lock;
    return r;
  endfunction

  function automatic abg_pkg::req_t rand_req();
    return mk_req(1'($urandom_range(1)), {$urandom, $urandom}, 8'($urandom),
                  3'($urandom), 2'($urandom), 1'($urandom_range(1)),
                  3'($urandom), 1'($urandom_range(1)));
  endfunction

  function automatic abg_pkg::req_t beat_cmd();
    abg_pkg::req_t r;
    r = rand_req();
    r.cmd = abg_pkg::CMD_BEAT;
    return r;
  endfunction

  function automatic abg_pkg::beat_t fault_beat(logic [2:0] f);
    abg_pkg::beat_t b;
    b = '0;
    b.fault = f;
    return b;
  endfunction

  function automatic logic [63:0] rand_addr();
    case ($urandom_range(3))
      0: return {$urandom, $urandom};
      1: return 64'hFFFF_FFFF_FFFF_FF00 | 64'($urandom_range(255));
      2: return {$urandom, $urandom} & ~64'hFF;
      default: return 64'($urandom_range(4095));
    endcase
  endfunction

  task automatic add_row(abg_pkg::req_t r, bit typed, abg_pkg::beat_t want);
    dir_row_t row;
    row.stim = r;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  task automatic report_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t %s expected %h got %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  task automatic send_req(abg_pkg::req_t r, bit typed, abg_pkg::beat_t want);
    abg_pkg::beat_t b;
    while ($urandom_range(99) < tx_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    b = step_burst(r);
    pending_beats.push_back(typed ? want : b);
    items_sent++;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_access(logic wr, logic idx, logic [2:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= {29'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (!wr && prdata !== {29'd0, val}) begin
      $display("%0t register %0d expected %h got %h", $time, idx, {29'd0, val}, prdata);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_reg(logic idx, logic [2:0] val);
    reg_access(1'b1, idx, val);
    if (idx == abg_pkg::REG_BUS) bus_lg = val;
    else strobe_lg = val;
    reg_access(1'b0, idx, val);
  endtask

  task automatic run_sequence();
    abg_pkg::req_t r;
    int            n;
    int            len1;
    if ($urandom_range(4) == 0) begin
      send_req(rand_req(), 1'b0, '0);
      return;
    end
    r = rand_req();
    r.cmd = abg_pkg::CMD_START;
    r.req_addr = rand_addr();
    r.beat_size_log2 = 3'($urandom_range(int'(bus_lg)));
    r.burst_kind = 2'($urandom_range(2));
    if (r.burst_kind == abg_pkg::KIND_WRAP) begin
      case ($urandom_range(3))
        0: r.beats_minus_one = 8'd1;
        1: r.beats_minus_one = 8'd3;
        2: r.beats_minus_one = 8'd7;
        default: r.beats_minus_one = 8'd15;
      endcase
    end else if ($urandom_range(49) == 0) begin
      r.beats_minus_one = 8'($urandom_range(255));
    end else begin
      r.beats_minus_one = 8'($urandom_range(7));
    end
    len1 = int'(r.beats_minus_one) + 1;
    n = len1;
    case ($urandom_range(9))
      0: n = int'($urandom_range(len1 - 1));
      1: n = len1 + 1;
      default: ;
    endcase
    send_req(r, 1'b0, '0);
    repeat (n) send_req(beat_cmd(), 1'b0, '0);
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t timeout, %0d beats outstanding", $time, pending_beats.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && beat_valid && !beat_stall) begin
      if (pending_beats.size() == 0) begin
        $display("%0t unexpected beat: expected none got %h", $time, beat);
        mismatches++;
      end else begin
        due_beat = pending_beats.pop_front();
        report_field("beat_addr", due_beat.beat_addr, beat.beat_addr);
        report_field("xfer_start", due_beat.xfer_start, beat.xfer_start);
        report_field("byte_count", 64'(due_beat.byte_count), 64'(beat.byte_count));
        report_field("low_lane", 64'(due_beat.low_lane), 64'(beat.low_lane));
        report_field("high_lane", 64'(due_beat.high_lane), 64'(beat.high_lane));
        report_field("last_beat", 64'(due_beat.last_beat), 64'(beat.last_beat));
        report_field("do_read", 64'(due_beat.do_read), 64'(beat.do_read));
        report_field("do_write", 64'(due_beat.do_write), 64'(beat.do_write));
        report_field("send_read_resp", 64'(due_beat.send_read_resp),
                     64'(beat.send_read_resp));
        report_field("exokay", 64'(due_beat.exokay), 64'(beat.exokay));
        report_field("fault", 64'(due_beat.fault), 64'(beat.fault));
      end
    end
    if (hold_seen != hold_trig) begin
      hold_seen = hold_trig;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      beat_stall <= 1'b1;
    end else begin
      beat_stall <= ($urandom_range(99) < rx_idle);
    end
  end

  initial begin
    logic [2:0] cfg_bus[8];
    logic [2:0] cfg_strobe[8];
    int         phase_start;
    cfg_bus    = '{3'd0, 3'd7, 3'd2, 3'd5, 3'd6, 3'd1, 3'd4, 3'd3};
    cfg_strobe = '{3'd0, 3'd7, 3'd5, 3'd2, 3'd0, 3'd7, 3'd4, 3'd3};

    // directed rows, bus and strobe at reset width (8 bytes)
    add_row(beat_cmd(), 1'b1, fault_beat(abg_pkg::FAULT_IDLE));
    add_row(mk_req(abg_pkg::CMD_START, '0, 8'd0, 3'd4, abg_pkg::KIND_INCR, 1'b0,
                   abg_pkg::ATOM_NONE, 1'b0), 1'b1, fault_beat(abg_pkg::FAULT_SIZE));
    add_row(mk_req(abg_pkg::CMD_START, '0, 8'd0, 3'd2, abg_pkg::KIND_RSVD, 1'b0,
                   abg_pkg::ATOM_NONE, 1'b0), 1'b1, fault_beat(abg_pkg::FAULT_RSVD));
    add_row(mk_req(abg_pkg::CMD_START, '1, 8'hFF, 3'd7, abg_pkg::KIND_RSVD, 1'b1, 3'd7,
                   1'b1), 1'b1, fault_beat(abg_pkg::FAULT_SIZE));
    add_row(mk_req(abg_pkg::CMD_START, 64'h40, 8'd2, 3'd2, abg_pkg::KIND_WRAP, 1'b0,
                   abg_pkg::ATOM_NONE, 1'b0), 1'b1, fault_beat(abg_pkg::FAULT_WRAP));
    add_row(mk_req(abg_pkg::CMD_START, 64'h40, 8'hFF, 3'd3, abg_pkg::KIND_WRAP, 1'b0,
                   abg_pkg::ATOM_NONE, 1'b0), 1'b1, fault_beat(abg_pkg::FAULT_WRAP));
    add_row(mk_req(abg_pkg::CMD_START, 64'hFFFF_FFFF_FFFF_FFF6, 8'd3, 3'd2,
                   abg_pkg::KIND_INCR, 1'b1, abg_pkg::ATOM_NONE, 1'b0), 1'b1,
            fault_beat(abg_pkg::FAULT_OK));
    repeat (4) add_row(beat_cmd(), 1'b0, '0);
    add_row(beat_cmd(), 1'b1, fault_beat(abg_pkg::FAULT_IDLE));
    add_row(mk_req(abg_pkg::CMD_START, 64'hFFFF_FFFF_FFFF_FFE8, 8'd3, 3'd3,
                   abg_pkg::KIND_WRAP, 1'b0, abg_pkg::ATOM_COMPARE, 1'b1), 1'b1,
            fault_beat(abg_pkg::FAULT_OK));
    repeat (4) add_row(beat_cmd(), 1'b0, '0);
    add_row(mk_req(abg_pkg::CMD_START, '1, 8'hFF, 3'd0, abg_pkg::KIND_FIXED, 1'b1, 3'd7,
                   1'b1), 1'b1, fault_beat(abg_pkg::FAULT_OK));
    repeat (2) add_row(beat_cmd(), 1'b0, '0);
    // replaces the running fixed burst
    add_row(mk_req(abg_pkg::CMD_START, 64'h1003, 8'd15, 3'd1, abg_pkg::KIND_WRAP, 1'b1,
                   abg_pkg::ATOM_STORE, 1'b0), 1'b1, fault_beat(abg_pkg::FAULT_OK));
    repeat (2) add_row(beat_cmd(), 1'b0, '0);
    add_row(mk_req(abg_pkg::CMD_START, '0, 8'd0, 3'd3, abg_pkg::KIND_INCR, 1'b1,
                   abg_pkg::ATOM_LOAD, 1'b1), 1'b1, fault_beat(abg_pkg::FAULT_OK));
    add_row(beat_cmd(), 1'b0, '0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    reg_access(1'b0, abg_pkg::REG_BUS, abg_pkg::BUS_LOG2_RST);
    reg_access(1'b0, abg_pkg::REG_STROBE, abg_pkg::STROBE_LOG2_RST);

    foreach (dir_rows[i]) send_req(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

    for (int p = 0; p < 8; p++) begin
      drain();
      set_reg(abg_pkg::REG_BUS, cfg_bus[p]);
      set_reg(abg_pkg::REG_STROBE, cfg_strobe[p]);
      if (p < 3) begin
        tx_idle = 8;
        rx_idle = 85;
      end else if (p < 6) begin
        tx_idle = 85;
        rx_idle = 8;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      // long output hold-off while requests keep coming
      if (p == 6) hold_trig++;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) run_sequence();
    end
    drain();

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: axi_burst_beat_generator_top.f
src/abg_pkg.sv
src/abg_front.sv
src/abg_queue.sv
src/abg_back.sv
src/axi_burst_beat_generator_top.sv
tb/axi_burst_beat_generator_top_test.sv
